FILE: hdl/tcce_pkg.sv
// shared constants for the text console character engine
package tcce_pkg;

	// screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;

	// field widths
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CH_W   = 8;
	localparam int POS_W  = 11;
	localparam int CFG_IW = 1;

	// request kinds
	localparam logic REQ_PUT  = 1'b0;
	localparam logic REQ_GOTO = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] REG_LEFT_MARGIN = 1'b0;
	localparam logic [CFG_IW-1:0] REG_WRAP_COLUMN = 1'b1;

	// character codes
	localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CH_W-1:0] CH_BS    = 8'h08;
	localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CH_W-1:0] CH_SPACE = 8'h20;

	localparam int TAB_STEP = 8;

endpackage

FILE: hdl/text_console_char_engine.sv
// text console character engine: cursor tracking and cell write generation
// a request is held in the request register, then in the result register, which drives the result ports
// throughput: one request per cycle while out_ready is not held low; the cursor update is one short pass
//   between the request register and the result register
// reset: arst_n clears the cursor to the top-left cell, left margin to 0,
//   wrap column to the column count, and empties both stages
module text_console_char_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [tcce_pkg::CH_W-1:0]     char_code,
	input  logic [tcce_pkg::CH_W-1:0]     attr,
	input  logic [7:0]                    goto_col,
	input  logic [7:0]                    goto_row,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          cell_write,
	output logic [tcce_pkg::POS_W-1:0]    cell_index,
	output logic [tcce_pkg::CH_W-1:0]     cell_char,
	output logic [tcce_pkg::CH_W-1:0]     cell_attr,
	output logic                          scroll_up,
	output logic [tcce_pkg::COL_W-1:0]    cursor_col,
	output logic [tcce_pkg::ROW_W-1:0]    cursor_row,
	output logic [tcce_pkg::POS_W-1:0]    cursor_pos,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [tcce_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [tcce_pkg::COL_W-1:0]    cfg_wdata
);

	localparam logic [tcce_pkg::COL_W-1:0] COL_LIMIT = tcce_pkg::COL_W'(tcce_pkg::COLUMNS);
	localparam logic [tcce_pkg::COL_W-1:0] COL_LAST  =
		tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
	localparam logic [tcce_pkg::ROW_W-1:0] ROW_LIMIT = tcce_pkg::ROW_W'(tcce_pkg::ROWS);
	localparam logic [tcce_pkg::ROW_W-1:0] ROW_LAST  = tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1);
	localparam logic [tcce_pkg::COL_W-1:0] TAB_ADD   = tcce_pkg::COL_W'(tcce_pkg::TAB_STEP);
	localparam logic [tcce_pkg::COL_W-1:0] TAB_MASK  =
		~tcce_pkg::COL_W'(tcce_pkg::TAB_STEP - 1);

	// configuration registers
	logic [tcce_pkg::COL_W-1:0] left_margin_q;
	logic [tcce_pkg::COL_W-1:0] wrap_column_q;

	// cursor state
	logic [tcce_pkg::COL_W-1:0] cur_col_q;
	logic [tcce_pkg::ROW_W-1:0] cur_row_q;

	// request stage
	logic                       valid_s1;
	logic                       req_type_s1;
	logic [tcce_pkg::CH_W-1:0]  char_code_s1;
	logic [tcce_pkg::CH_W-1:0]  attr_s1;
	logic [7:0]                 goto_col_s1;
	logic [7:0]                 goto_row_s1;

	// result stage
	logic                       valid_s2;
	logic                       cell_write_s2;
	logic [tcce_pkg::POS_W-1:0] cell_index_s2;
	logic [tcce_pkg::CH_W-1:0]  cell_char_s2;
	logic [tcce_pkg::CH_W-1:0]  cell_attr_s2;
	logic                       scroll_up_s2;
	logic [tcce_pkg::COL_W-1:0] cursor_col_s2;
	logic [tcce_pkg::ROW_W-1:0] cursor_row_s2;
	logic [tcce_pkg::POS_W-1:0] cursor_pos_s2;

	// handshake: the result register frees as soon as its transfer happens
	logic adv_s2;
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	// ---------------------------------------------------------------
	// cursor logic for the request sitting in stage 1
	// ---------------------------------------------------------------
	logic [tcce_pkg::COL_W-1:0] col_a;     // column after the character action
	logic [tcce_pkg::ROW_W-1:0] row_a;     // row after the character action
	logic [tcce_pkg::COL_W-1:0] col_b;     // column after the wrap check
	logic [tcce_pkg::ROW_W-1:0] row_b;     // row after wrap, before clamp
	logic [tcce_pkg::COL_W-1:0] col_nxt;
	logic [tcce_pkg::ROW_W-1:0] row_nxt;
	logic                       do_wrap;   // put request that runs wrap/scroll checks
	logic                       do_check;  // any request that runs the scroll check
	logic                       wr_nxt;
	logic [tcce_pkg::COL_W-1:0] wcol;      // cell written, column
	logic [tcce_pkg::ROW_W-1:0] wrow;      // cell written, row
	logic [tcce_pkg::CH_W-1:0]  wchar;
	logic                       scroll_nxt;
	logic [tcce_pkg::POS_W-1:0] idx_nxt;
	logic [tcce_pkg::POS_W-1:0] pos_nxt;

	always_comb begin
		col_a    = cur_col_q;
		row_a    = cur_row_q;
		wr_nxt   = 1'b0;
		wcol     = cur_col_q;
		wrow     = cur_row_q;
		wchar    = char_code_s1;
		do_wrap  = 1'b0;
		do_check = 1'b0;
		if (req_type_s1 == tcce_pkg::REQ_GOTO) begin
			// each coordinate is taken only when it does not exceed the column or row count
			if (goto_col_s1 <= 8'(tcce_pkg::COLUMNS)) begin
				col_a = goto_col_s1[tcce_pkg::COL_W-1:0];
			end
			if (goto_row_s1 <= 8'(tcce_pkg::ROWS)) begin
				row_a = goto_row_s1[tcce_pkg::ROW_W-1:0];
			end
			do_check = 1'b1;
		end else if (char_code_s1 != tcce_pkg::CH_NUL) begin
			do_wrap  = 1'b1;
			do_check = 1'b1;
			if (char_code_s1 == tcce_pkg::CH_BS) begin
				// step back, moving to the end of the row above at column 0;
				// the top-left cell stays put and is blanked anyway
				if (cur_col_q != '0) begin
					col_a = cur_col_q - 1'b1;
				end else if (cur_row_q != '0) begin
					col_a = COL_LAST;
					row_a = cur_row_q - 1'b1;
				end
				wr_nxt = 1'b1;
				wcol   = col_a;
				wrow   = row_a;
				wchar  = tcce_pkg::CH_SPACE;
			end else if (char_code_s1 == tcce_pkg::CH_TAB) begin
				col_a = (cur_col_q + TAB_ADD) & TAB_MASK;
			end else if (char_code_s1 == tcce_pkg::CH_LF) begin
				col_a = left_margin_q;
				row_a = cur_row_q + 1'b1;
			end else if (char_code_s1 == tcce_pkg::CH_CR) begin
				col_a = '0;
			end else if (char_code_s1 >= tcce_pkg::CH_SPACE) begin
				// a cursor parked past the last column writes nothing
				wr_nxt = (cur_col_q < COL_LIMIT);
				col_a  = cur_col_q + 1'b1;
			end
			// other control codes only run the wrap and scroll checks
		end

		// wrap to the left margin of the next row
		col_b = col_a;
		row_b = row_a;
		if (do_wrap && (col_a >= wrap_column_q)) begin
			col_b = left_margin_q;
			row_b = row_a + 1'b1;
		end

		// running off the bottom asks for a scroll and pins the row
		col_nxt    = col_b;
		row_nxt    = row_b;
		scroll_nxt = 1'b0;
		if (do_check && (row_b >= ROW_LIMIT)) begin
			row_nxt    = ROW_LAST;
			scroll_nxt = 1'b1;
		end

		// linear addresses, multiply by a constant column count
		idx_nxt = tcce_pkg::POS_W'(wrow) * tcce_pkg::POS_W'(tcce_pkg::COLUMNS)
			+ tcce_pkg::POS_W'(wcol);
		pos_nxt = tcce_pkg::POS_W'(row_nxt) * tcce_pkg::POS_W'(tcce_pkg::COLUMNS)
			+ tcce_pkg::POS_W'(col_nxt);
	end

	// ---------------------------------------------------------------
	// control registers: valid bits, cursor and configuration
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			left_margin_q <= '0;
			wrap_column_q <= COL_LIMIT;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			// cursor moves when the request leaves stage 1
			if (valid_s1 && adv_s2) begin
				cur_col_q <= col_nxt;
				cur_row_q <= row_nxt;
			end
			// values beyond the column count are dropped
			if (cfg_we && (cfg_wdata <= COL_LIMIT)) begin
				unique case (cfg_index)
					tcce_pkg::REG_LEFT_MARGIN: left_margin_q <= cfg_wdata;
					tcce_pkg::REG_WRAP_COLUMN: wrap_column_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_type_s1  <= req_type;
			char_code_s1 <= char_code;
			attr_s1      <= attr;
			goto_col_s1  <= goto_col;
			goto_row_s1  <= goto_row;
		end
		if (valid_s1 && adv_s2) begin
			cell_write_s2 <= wr_nxt;
			cell_index_s2 <= wr_nxt ? idx_nxt : '0;
			cell_char_s2  <= wr_nxt ? wchar : '0;
			cell_attr_s2  <= wr_nxt ? attr_s1 : '0;
			scroll_up_s2  <= scroll_nxt;
			cursor_col_s2 <= col_nxt;
			cursor_row_s2 <= row_nxt;
			cursor_pos_s2 <= pos_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign cell_write = cell_write_s2;
	assign cell_index = cell_index_s2;
	assign cell_char  = cell_char_s2;
	assign cell_attr  = cell_attr_s2;
	assign scroll_up  = scroll_up_s2;
	assign cursor_col = cursor_col_s2;
	assign cursor_row = cursor_row_s2;
	assign cursor_pos = cursor_pos_s2;

endmodule

FILE: hdl/tcce_checker.sv
// port-level checks for the text console character engine, bound to the top level
module tcce_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          cell_write,
	input logic [tcce_pkg::POS_W-1:0]    cell_index,
	input logic [tcce_pkg::CH_W-1:0]     cell_char,
	input logic [tcce_pkg::CH_W-1:0]     cell_attr,
	input logic                          scroll_up,
	input logic [tcce_pkg::COL_W-1:0]    cursor_col,
	input logic [tcce_pkg::ROW_W-1:0]    cursor_row,
	input logic [tcce_pkg::POS_W-1:0]    cursor_pos
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cursor_pos)
			&& $stable(cell_index) && $stable(scroll_up) && $stable(cell_write))
		else $error("result changed while stalled");

	// cursor stays on the screen, column may sit one past the last
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_row < tcce_pkg::ROW_W'(tcce_pkg::ROWS))
			&& (cursor_col <= tcce_pkg::COL_W'(tcce_pkg::COLUMNS)))
		else $error("cursor off screen");

	// linear cursor location agrees with column and row
	a_cursor_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_pos == tcce_pkg::POS_W'(cursor_row)
			* tcce_pkg::POS_W'(tcce_pkg::COLUMNS) + tcce_pkg::POS_W'(cursor_col))
		else $error("cursor_pos mismatch");

	// no write means quiet cell fields, a write stays on screen
	a_cell_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cell_write && cell_index
			< tcce_pkg::POS_W'(tcce_pkg::COLUMNS * tcce_pkg::ROWS))
			|| (!cell_write && cell_index == '0 && cell_char == '0 && cell_attr == '0))
		else $error("bad cell write fields");

endmodule

bind text_console_char_engine tcce_checker u_tcce_checker (.*);
